### rtl/sopc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopc_pkg
// Shared types and constants of the second-order position compensator:
// fixed-point widths, multiplier operand types, register indexes, resets.
// ----------------------------------------------------------------------------
package sopc_pkg;

  // Q16.16 data, Q8.24 gains
  localparam int POS_W   = 32;
  localparam int DRV_W   = 32;
  localparam int GAIN_W  = 32;
  localparam int LIM_W   = 31;
  localparam int FRAC_W  = 24;

  // operands are sign-extended to VAL_W and multiplied in two chunks
  localparam int VAL_W   = 48;
  localparam int A_W     = GAIN_W + 1;
  localparam int B_W     = FRAC_W + 1;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = VAL_W + GAIN_W + 4;
  localparam int RND_W   = ACC_W - FRAC_W;

  typedef logic signed [A_W-1:0]    mul_a_t;
  typedef logic signed [B_W-1:0]    mul_b_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  localparam acc_t RND_HALF = acc_t'(1) <<< (FRAC_W - 1);

  // control word from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // operands are valid this cycle
    logic hi;   // operand b is the upper chunk: weight by 2^FRAC_W
  } mac_ctrl_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_GAIN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_GAIN_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_REV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT    = 3'd6;

  // reset values
  localparam logic signed [GAIN_W-1:0] RST_ERROR_GAIN     = 32'sd1150581473;
  localparam logic signed [GAIN_W-1:0] RST_COMMAND_GAIN_1 = 32'sd16810770;
  localparam logic signed [GAIN_W-1:0] RST_ERROR_GAIN_1   = -32'sd1910924902;
  localparam logic signed [GAIN_W-1:0] RST_COMMAND_GAIN_2 = -32'sd33722;
  localparam logic signed [GAIN_W-1:0] RST_ERROR_GAIN_2   = 32'sd842216243;
  localparam logic [GAIN_W-1:0]        RST_METERS_PER_REV = 32'd0;
  localparam logic [LIM_W-1:0]         RST_DRIVE_LIMIT    = 31'd327680;

endpackage

### rtl/second_order_position_compensator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_position_compensator
// Saturated second-order difference-equation position compensator.
// ----------------------------------------------------------------------------
// One input word {rotor_pos, target_pos} yields one output word: the drive
// command clamped to +/- drive_limit, with out_tuser set when the clamp acted.
// A single 33x25 multiplier with a wide accumulator does all products, each
// 32-bit operand pair in two chunks: two passes for the scaled rotor position
// and ten for the five terms. A new word can be accepted in the same cycle
// that out_tvalid rises. in_tready is high only between items; a finished
// word waits in the output register while the next item is computed.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
module second_order_position_compensator
  import sopc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream: [31:0] target_pos, [63:32] rotor_pos
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,
  // output stream: [31:0] drive
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  // output flag: [0] clamped
  output logic [0:0]           out_tuser,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_POS_MUL, ST_POS_RND, ST_ERR, ST_SUM_MUL, ST_SUM_RND, ST_CLAMP
  } state_t;

  typedef logic signed [RND_W:0] err_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] POS_STEPS = STEP_W'(2);
  localparam logic [STEP_W-1:0] SUM_STEPS = STEP_W'(10);

  // product terms, two multiplier passes each
  localparam logic [2:0] TERM_ERR  = 3'd0;
  localparam logic [2:0] TERM_DRV1 = 3'd1;
  localparam logic [2:0] TERM_ERR1 = 3'd2;
  localparam logic [2:0] TERM_DRV2 = 3'd3;
  localparam logic [2:0] TERM_ERR2 = 3'd4;
  localparam logic [2:0] TERM_POS  = 3'd5;

  localparam err_t ERR_MAX = err_t'({(DATA_WIDTH-1){1'b1}});
  localparam err_t ERR_MIN = ~ERR_MAX;

  // configuration
  logic signed [GAIN_W-1:0] eg0_r, cg1_r, eg1_r, cg2_r, eg2_r;
  logic [GAIN_W-1:0]        mpr_r;
  logic [LIM_W-1:0]         lim_r;

  // sequencer and datapath registers
  state_t                       state_r, state_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic signed [POS_W-1:0]      tgt_r, tgt_nxt;
  logic signed [POS_W-1:0]      rot_r, rot_nxt;
  rnd_t                         rnd_r, rnd_nxt;
  logic signed [DATA_WIDTH-1:0] err_r, err_nxt;
  logic signed [DATA_WIDTH-1:0] last_err_r, last_err_nxt;
  logic signed [DATA_WIDTH-1:0] older_err_r, older_err_nxt;
  logic signed [DRV_W-1:0]      last_drv_r, last_drv_nxt;
  logic signed [DRV_W-1:0]      older_drv_r, older_drv_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [31:0]                  out_tdata_r, out_tdata_nxt;
  logic                         out_clamp_r, out_clamp_nxt;

  logic      in_acc;
  logic      out_free;
  logic [2:0] term;
  mul_a_t    op_a;
  mul_b_t    op_b;
  val_t      op_v;
  mac_ctrl_t ctrl;
  acc_t      acc;
  acc_t      acc_rnd;
  rnd_t      rnd_val;
  err_t      err_full;
  logic signed [DATA_WIDTH-1:0] err_sat;
  rnd_t      lim_s;
  rnd_t      drv_full;
  logic      drv_clamp;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_clamp_r;

  // operand select for the shared multiplier
  always_comb begin
    term = (state_r == ST_SUM_MUL) ? step_r[3:1] : TERM_POS;
    case (term)
      TERM_ERR: begin
        op_a = mul_a_t'(eg0_r);
        op_v = val_t'(err_r);
      end
      TERM_DRV1: begin
        op_a = mul_a_t'(cg1_r);
        op_v = val_t'(last_drv_r);
      end
      TERM_ERR1: begin
        op_a = mul_a_t'(eg1_r);
        op_v = val_t'(last_err_r);
      end
      TERM_DRV2: begin
        op_a = mul_a_t'(cg2_r);
        op_v = val_t'(older_drv_r);
      end
      TERM_ERR2: begin
        op_a = mul_a_t'(eg2_r);
        op_v = val_t'(older_err_r);
      end
      default: begin
        op_a = mul_a_t'(mpr_r);
        op_v = val_t'(rot_r);
      end
    endcase
    op_b = step_r[0] ? mul_b_t'(signed'(op_v[VAL_W-1:FRAC_W]))
                     : mul_b_t'(op_v[FRAC_W-1:0]);
    ctrl.vld = ((state_r == ST_POS_MUL) && (step_r < POS_STEPS)) ||
               ((state_r == ST_SUM_MUL) && (step_r < SUM_STEPS));
    ctrl.hi  = step_r[0];
    ctrl.clr = in_acc || (state_r == ST_ERR);
  end

  sopc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // rounding, error saturation and drive clamp
  always_comb begin
    acc_rnd  = acc + RND_HALF;
    rnd_val  = rnd_t'(signed'(acc_rnd[ACC_W-1:FRAC_W]));
    err_full = err_t'(tgt_r) - err_t'(rnd_r);
    if (err_full > ERR_MAX) begin
      err_sat = ERR_MAX[DATA_WIDTH-1:0];
    end else if (err_full < ERR_MIN) begin
      err_sat = ERR_MIN[DATA_WIDTH-1:0];
    end else begin
      err_sat = err_full[DATA_WIDTH-1:0];
    end
    lim_s = rnd_t'({1'b0, lim_r});
    if (rnd_r > lim_s) begin
      drv_full  = lim_s;
      drv_clamp = 1'b1;
    end else if (rnd_r < -lim_s) begin
      drv_full  = -lim_s;
      drv_clamp = 1'b1;
    end else begin
      drv_full  = rnd_r;
      drv_clamp = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    tgt_nxt        = tgt_r;
    rot_nxt        = rot_r;
    rnd_nxt        = rnd_r;
    err_nxt        = err_r;
    last_err_nxt   = last_err_r;
    older_err_nxt  = older_err_r;
    last_drv_nxt   = last_drv_r;
    older_drv_nxt  = older_drv_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_clamp_nxt  = out_clamp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          tgt_nxt   = in_tdata[31:0];
          rot_nxt   = in_tdata[63:32];
          step_nxt  = '0;
          state_nxt = ST_POS_MUL;
        end
      end
      ST_POS_MUL: begin
        // last step only drains the product register
        if (step_r == POS_STEPS) begin
          state_nxt = ST_POS_RND;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_POS_RND: begin
        rnd_nxt   = rnd_val;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        err_nxt   = err_sat;
        step_nxt  = '0;
        state_nxt = ST_SUM_MUL;
      end
      ST_SUM_MUL: begin
        if (step_r == SUM_STEPS) begin
          state_nxt = ST_SUM_RND;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SUM_RND: begin
        rnd_nxt   = rnd_val;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        // hold until the output register is free
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = drv_full[DRV_W-1:0];
          out_clamp_nxt  = drv_clamp;
          older_drv_nxt  = last_drv_r;
          last_drv_nxt   = drv_full[DRV_W-1:0];
          older_err_nxt  = last_err_r;
          last_err_nxt   = err_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      last_err_r   <= '0;
      older_err_r  <= '0;
      last_drv_r   <= '0;
      older_drv_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      last_err_r   <= last_err_nxt;
      older_err_r  <= older_err_nxt;
      last_drv_r   <= last_drv_nxt;
      older_drv_r  <= older_drv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    tgt_r       <= tgt_nxt;
    rot_r       <= rot_nxt;
    rnd_r       <= rnd_nxt;
    err_r       <= err_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eg0_r <= RST_ERROR_GAIN;
      cg1_r <= RST_COMMAND_GAIN_1;
      eg1_r <= RST_ERROR_GAIN_1;
      cg2_r <= RST_COMMAND_GAIN_2;
      eg2_r <= RST_ERROR_GAIN_2;
      mpr_r <= RST_METERS_PER_REV;
      lim_r <= RST_DRIVE_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ERROR_GAIN:     eg0_r <= cfg_wr_data;
        CFG_COMMAND_GAIN_1: cg1_r <= cfg_wr_data;
        CFG_ERROR_GAIN_1:   eg1_r <= cfg_wr_data;
        CFG_COMMAND_GAIN_2: cg2_r <= cfg_wr_data;
        CFG_ERROR_GAIN_2:   eg2_r <= cfg_wr_data;
        CFG_METERS_PER_REV: mpr_r <= cfg_wr_data;
        CFG_DRIVE_LIMIT:    lim_r <= cfg_wr_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_POS_MUL) && (step_r == '0))
    else $error("accepted word did not start the position pass");

  a_mac_only_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.vld |-> (state_r == ST_POS_MUL) || (state_r == ST_SUM_MUL))
    else $error("multiplier issued outside a multiply pass");

  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP) |-> (drv_full <= lim_s) && (drv_full >= -lim_s))
    else $error("drive outside the saturation bound");
`endif

endmodule

### rtl/sopc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopc_mac
// Shared multiply-accumulate unit: one registered signed multiply per cycle,
// then an exact add of the product into a wide accumulator.
// ----------------------------------------------------------------------------
module sopc_mac
  import sopc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mac_ctrl_t ctrl,
  input  mul_a_t    op_a,
  input  mul_b_t    op_b,
  output acc_t      acc
);

  prod_t prod_r;
  logic  prod_vld_r;
  logic  prod_hi_r;
  acc_t  acc_r;
  acc_t  addend;

  always_comb begin
    addend = prod_hi_r ? (acc_t'(prod_r) <<< FRAC_W) : acc_t'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      prod_hi_r  <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctrl.vld;
      prod_hi_r  <= ctrl.hi;
      if (ctrl.clr) begin
        acc_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + addend;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign acc = acc_r;

endmodule
